>>> design/rndis_packet_deframer_defines.svh
// ----------------------------------------------------------------------------
// RNDIS packet deframer assertion macros
// Concurrent check wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RNDIS_PACKET_DEFRAMER_DEFINES_SVH
`define RNDIS_PACKET_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled during reset
`define RPDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpdf: assertion failed");
// next-cycle implication, disabled during reset
`define RPDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpdf: assertion failed");
`else
`define RPDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RPDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/rpdf_pkg.sv
// ----------------------------------------------------------------------------
// RNDIS packet deframer package
// Shared constants, status codes and the command word passed front to back.
// ----------------------------------------------------------------------------
package rpdf_pkg;

    localparam int MAX_TRANSFER_BYTES_DEF = 16384;

    // command queue depth, power of two
    localparam int QUEUE_DEPTH = 4;

    localparam int HDR_BYTES   = 16;
    localparam int BASE_BYTES  = 8;
    localparam logic [31:0] TYPE_PACKET = 32'd1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT_TAIL  = 3'd1,
        ST_WRONG_TYPE  = 3'd2,
        ST_TOO_LONG    = 3'd3,
        ST_ZERO_LENGTH = 3'd4,
        ST_TRUNCATED   = 3'd5,
        ST_EMPTY_FRAME = 3'd6
    } status_t;

    // One queued command: a status event, or a run of payload bytes taken
    // from slots first..last of bytes (slot 0 = header byte 8 on release).
    typedef struct packed {
        logic            is_status;
        status_t         code;
        logic [7:0][7:0] bytes;
        logic [2:0]      first;
        logic [2:0]      last;
        logic            fend;
    } rpdf_cmd_t;

endpackage

>>> design/rpdf_front.sv
// ----------------------------------------------------------------------------
// RNDIS packet deframer front end
// Tracks transfer and message position, checks headers, queues commands.
// ----------------------------------------------------------------------------
module rpdf_front import rpdf_pkg::*; #(
    parameter int MAX_TRANSFER_BYTES = MAX_TRANSFER_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       transfer_start,
    input  logic [14:0] transfer_length,
    output logic       cmd_valid,
    output rpdf_cmd_t  cmd,
    input  logic       cmd_ready
);

    localparam int RW = $clog2(MAX_TRANSFER_BYTES + 1);
    localparam int PW = $clog2(MAX_TRANSFER_BYTES + 8);
    localparam int XW = (RW > 15) ? RW : 15;

    logic [7:0]    hs_reg [HDR_BYTES];
    logic [PW-1:0] pos_reg, pos_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic          disc_reg, disc_next;
    logic [PW-1:0] cml_reg, cml_next;
    logic [PW-1:0] ps_reg, ps_next;
    logic [PW-1:0] pl_reg, pl_next;

    logic          accept, live, disc_cur, fail, emit, hs_we;
    logic [XW-1:0] tl_ext, tl_sat;
    logic [RW-1:0] tl_len, rem_incl, rem_left;
    logic [PW-1:0] pos_cur, pos_inc, end_w;
    logic [31:0]   type_w, mlen, avail, off, dl;
    logic [33:0]   need;
    logic [32:0]   ps_sum;
    status_t       code;

    assign in_ready = cmd_ready;
    assign accept   = in_valid && in_ready;

    // transfer length: zero counts as one, saturate at the maximum
    assign tl_ext = XW'(transfer_length);
    assign tl_sat = (tl_ext > XW'(MAX_TRANSFER_BYTES)) ? XW'(MAX_TRANSFER_BYTES) : tl_ext;
    assign tl_len = (tl_sat == '0) ? RW'(1) : RW'(tl_sat);

    assign live     = transfer_start || (rem_reg != '0);
    assign rem_incl = transfer_start ? tl_len : rem_reg;
    assign rem_left = rem_incl - RW'(1);
    assign disc_cur = transfer_start ? 1'b0 : disc_reg;
    assign pos_cur  = transfer_start ? '0 : pos_reg;
    assign pos_inc  = pos_cur + PW'(1);
    assign end_w    = ps_reg + pl_reg;

    // little-endian header fields, current byte is the top byte
    assign type_w = {hs_reg[3], hs_reg[2], hs_reg[1], hs_reg[0]};
    assign mlen   = {data_byte, hs_reg[6], hs_reg[5], hs_reg[4]};
    assign avail  = 32'(rem_incl) + 32'd7;
    assign off    = {hs_reg[11], hs_reg[10], hs_reg[9], hs_reg[8]};
    assign dl     = {data_byte, hs_reg[14], hs_reg[13], hs_reg[12]};
    assign need   = 34'(BASE_BYTES) + 34'(off) + 34'(dl);
    assign ps_sum = 33'(off) + 33'(BASE_BYTES);

    // classify the byte
    always_comb begin
        fail      = 1'b0;
        emit      = 1'b0;
        hs_we     = 1'b0;
        code      = ST_OK;
        cml_next  = cml_reg;
        ps_next   = ps_reg;
        pl_next   = pl_reg;
        cmd.is_status = 1'b0;
        cmd.code      = ST_OK;
        cmd.bytes     = {data_byte, hs_reg[14], hs_reg[13], hs_reg[12],
                         hs_reg[11], hs_reg[10], hs_reg[9], hs_reg[8]};
        cmd.first     = 3'd0;
        cmd.last      = 3'd0;
        cmd.fend      = 1'b0;
        if (live && !disc_cur) begin
            if (pos_cur == '0 && rem_incl < RW'(BASE_BYTES)) begin
                fail = 1'b1;
                code = ST_SHORT_TAIL;
            end else begin
                hs_we = (pos_cur < PW'(HDR_BYTES));
                if (pos_cur == PW'(7)) begin
                    priority if (type_w != TYPE_PACKET) begin
                        fail = 1'b1;
                        code = ST_WRONG_TYPE;
                    end else if (mlen > avail) begin
                        fail = 1'b1;
                        code = ST_TOO_LONG;
                    end else if (mlen == '0) begin
                        fail = 1'b1;
                        code = ST_ZERO_LENGTH;
                    end else if (mlen < 32'(HDR_BYTES)) begin
                        fail = 1'b1;
                        code = ST_TRUNCATED;
                    end else begin
                        cml_next = PW'(mlen);
                    end
                end else if (pos_cur == PW'(HDR_BYTES - 1)) begin
                    priority if (need > 34'(cml_reg)) begin
                        fail = 1'b1;
                        code = ST_TRUNCATED;
                    end else if (dl == '0) begin
                        fail = 1'b1;
                        code = ST_EMPTY_FRAME;
                    end else begin
                        ps_next = PW'(ps_sum);
                        pl_next = PW'(dl);
                        // payload starting inside the header is released now
                        if (off < 32'(HDR_BYTES - BASE_BYTES)) begin
                            emit      = 1'b1;
                            cmd.first = off[2:0];
                            if (need <= 34'(HDR_BYTES)) begin
                                cmd.last = 3'(need - 34'(BASE_BYTES + 1));
                                cmd.fend = 1'b1;
                            end else begin
                                cmd.last = 3'd7;
                            end
                        end
                    end
                end else if (pos_cur >= PW'(HDR_BYTES) && pos_cur >= ps_reg
                             && pos_cur < end_w) begin
                    emit         = 1'b1;
                    cmd.bytes[0] = data_byte;
                    cmd.fend     = (pos_inc == end_w);
                end
            end
        end
        if (fail) begin
            emit          = 1'b1;
            cmd.is_status = 1'b1;
            cmd.code      = code;
        end
    end

    assign cmd_valid = accept && emit;

    // position and transfer bookkeeping
    always_comb begin
        rem_next  = rem_reg;
        disc_next = disc_reg;
        pos_next  = pos_reg;
        if (live) begin
            rem_next = rem_left;
            if (fail || rem_left == '0) begin
                disc_next = 1'b1;
                pos_next  = '0;
            end else begin
                disc_next = disc_cur;
                if (disc_cur) begin
                    pos_next = pos_cur;
                end else if (pos_cur >= PW'(HDR_BYTES - 1) && pos_inc >= cml_reg) begin
                    pos_next = '0;
                end else begin
                    pos_next = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            rem_reg  <= '0;
            disc_reg <= 1'b1;
            cml_reg  <= '0;
            ps_reg   <= '0;
            pl_reg   <= '0;
        end else if (accept) begin
            pos_reg  <= pos_next;
            rem_reg  <= rem_next;
            disc_reg <= disc_next;
            cml_reg  <= cml_next;
            ps_reg   <= ps_next;
            pl_reg   <= pl_next;
        end
    end

    // header bytes, no reset
    always_ff @(posedge aclk) begin
        if (accept && hs_we) begin
            hs_reg[pos_cur[3:0]] <= data_byte;
        end
    end

endmodule

>>> design/rpdf_queue.sv
// ----------------------------------------------------------------------------
// RNDIS packet deframer command queue
// Small FIFO of commands between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module rpdf_queue import rpdf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  rpdf_cmd_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output rpdf_cmd_t pop_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rpdf_cmd_t     entry_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push_fire, pop_fire;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // pointers wrap by overflow, depth is a power of two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "rndis_packet_deframer_defines.svh"

    `RPDF_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, count_reg <= CW'(QUEUE_DEPTH))
    `RPDF_ASSERT_NXT(a_cnt_up, aclk, aresetn, push_fire && !pop_fire, count_reg == $past(count_reg) + CW'(1))
    `RPDF_ASSERT_NXT(a_cnt_dn, aclk, aresetn, pop_fire && !push_fire, count_reg == $past(count_reg) - CW'(1))

endmodule

>>> design/rpdf_back.sv
// ----------------------------------------------------------------------------
// RNDIS packet deframer output sequencer
// Expands queued commands into result words through an output register.
// ----------------------------------------------------------------------------
module rpdf_back import rpdf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cmd_valid,
    input  rpdf_cmd_t   cmd,
    output logic        cmd_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    output logic [0:0]  m_tuser
);

    logic       out_valid_reg, busy_reg;
    logic [2:0] idx_reg, idx;
    logic       kind_reg, fend_reg, run_last_reg;
    logic [7:0] byte_reg;
    status_t    code_reg;
    logic       adv, take, is_last;

    // output register is free or drains this cycle
    assign adv     = !out_valid_reg || m_tready;
    assign take    = adv && cmd_valid;
    assign idx     = busy_reg ? idx_reg : cmd.first;
    assign is_last = cmd.is_status || (idx == cmd.last);
    assign cmd_ready = take && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (adv) begin
                out_valid_reg <= cmd_valid;
            end
            if (take) begin
                busy_reg <= !is_last;
                idx_reg  <= idx + 3'd1;
            end
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (take) begin
            kind_reg     <= cmd.is_status;
            byte_reg     <= cmd.is_status ? 8'd0 : cmd.bytes[idx];
            fend_reg     <= !cmd.is_status && is_last && cmd.fend;
            code_reg     <= cmd.is_status ? cmd.code : ST_OK;
            run_last_reg <= is_last;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {4'b0000, run_last_reg, code_reg, byte_reg};
    assign m_tlast    = fend_reg;
    assign m_tuser[0] = kind_reg;

`include "rndis_packet_deframer_defines.svh"

    `RPDF_ASSERT_IMP(a_status_ends_run, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[11] && m_tdata[10:8] != ST_OK)
    `RPDF_ASSERT_IMP(a_payload_no_code, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[10:8] == ST_OK)
    `RPDF_ASSERT_IMP(a_fend_ends_run, aclk, aresetn, m_tvalid && m_tlast, m_tdata[11] && !m_tuser[0])

endmodule

>>> design/rndis_packet_deframer.sv
// ----------------------------------------------------------------------------
// RNDIS packet deframer
// Splits a byte stream of bulk transfers into packet-message payload frames.
// ----------------------------------------------------------------------------
// Takes one transfer byte per cycle. The first byte of a transfer is flagged
// in s_tuser and carries the transfer length. Each 16-byte little-endian
// message header is checked; payload bytes leave one per word with m_tlast on
// the last byte of a frame, and a failed check sends one status word and drops
// the rest of the transfer. Each byte is one input item and each result one
// output word, so the header's last byte, which releases any payload that
// started inside the header, can produce up to 8 result words. A 4-entry
// command queue between the header checker and the output sequencer absorbs
// that burst, and the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module rndis_packet_deframer import rpdf_pkg::*; #(
    parameter int MAX_TRANSFER_BYTES = MAX_TRANSFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], transfer_length[22:8], pad
    input  logic [0:0]  s_tuser,   // transfer_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // frame_byte[7:0], status_code[10:8], run_last[11], pad
    output logic        m_tlast,   // frame_end
    output logic [0:0]  m_tuser    // result_kind
);

    logic      q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    rpdf_cmd_t q_push_data, q_pop_data;

    rpdf_front #(
        .MAX_TRANSFER_BYTES(MAX_TRANSFER_BYTES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .data_byte       (s_tdata[7:0]),
        .transfer_start  (s_tuser[0]),
        .transfer_length (s_tdata[22:8]),
        .cmd_valid       (q_push_valid),
        .cmd             (q_push_data),
        .cmd_ready       (q_push_ready)
    );

    rpdf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    rpdf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_pop_valid),
        .cmd       (q_pop_data),
        .cmd_ready (q_pop_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
